// ----- sv/mp2d_pkg.sv -----
`default_nettype none

package mp2d_pkg;

  // Sizing of the line store and the pooling window.
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_WINDOW  = 8;
  localparam int SAMPLE_BITS = 32;

  // Derived widths.
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WEFF_W      = $clog2(MAX_WIDTH + 1);
  localparam int NRC_W       = $clog2(MAX_WIDTH + 16);
  localparam int WIN_CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int TREE_LEAVES = 1 << $clog2(MAX_WINDOW);

  // Fixed register widths of the configuration port.
  localparam int ROW_W    = 13;
  localparam int NBR_W    = 14;
  localparam int STEP_W   = 4;
  localparam int PCOUNT_W = 16;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] col_word_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [WIN_CNT_W-1:0] win_cnt_t;

  localparam sample_t MOST_NEG = sample_t'({1'b1, {(SAMPLE_BITS-1){1'b0}}});

  // Register indexes, one word apart on the configuration port.
  typedef enum logic [2:0] {
    REG_PLANE_HEIGHT  = 3'd0,
    REG_PLANE_WIDTH   = 3'd1,
    REG_WINDOW_HEIGHT = 3'd2,
    REG_WINDOW_WIDTH  = 3'd3,
    REG_STEP_ROWS     = 3'd4,
    REG_STEP_COLS     = 3'd5,
    REG_PLANE_COUNT   = 3'd6
  } reg_idx_e;

  // Effective geometry after clamping of the raw registers.
  typedef struct packed {
    logic [ROW_W-1:0]    h;
    logic [WEFF_W-1:0]   w;
    win_cnt_t            wh;
    win_cnt_t            ww;
    logic [STEP_W-1:0]   sr;
    logic [STEP_W-1:0]   sc;
    logic [PCOUNT_W-1:0] pc;
  } cfg_t;

  // Stream position restart on a register write, with the new window size.
  typedef struct packed {
    logic     restart;
    win_cnt_t wh;
    win_cnt_t ww;
  } restart_t;

  // Result tags that travel down the pipeline with each sample.
  typedef struct packed {
    logic emit;
    logic plane_done;
    logic all_done;
  } item_t;

  // Window size register: zero reads as one, oversize as the largest window.
  function automatic win_cnt_t clamp_win(logic [3:0] v);
    win_cnt_t r;
    if (v == 4'd0) begin
      r = win_cnt_t'(1);
    end else if (int'(v) > MAX_WINDOW) begin
      r = win_cnt_t'(MAX_WINDOW);
    end else begin
      r = win_cnt_t'(v);
    end
    return r;
  endfunction

  // Maximum over the newest n entries (entry 0 is newest), as a compare tree.
  function automatic sample_t win_max(col_word_t v, win_cnt_t n);
    sample_t t [TREE_LEAVES];
    for (int i = 0; i < TREE_LEAVES; i++) begin
      t[i] = MOST_NEG;
    end
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (i < int'(n)) begin
        t[i] = $signed(v[i]);
      end
    end
    for (int s = 1; s < TREE_LEAVES; s = s * 2) begin
      for (int i = 0; i + s < TREE_LEAVES; i = i + 2 * s) begin
        if (t[i+s] > t[i]) begin
          t[i] = t[i+s];
        end
      end
    end
    return t[0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/mp2d_cfg.sv -----
`default_nettype none

module mp2d_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mp2d_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mp2d_pkg::DATA_W-1:0] pwdata,
  output logic      [mp2d_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output mp2d_pkg::cfg_t                  cfg_o,
  output mp2d_pkg::restart_t              restart_o
);
  import mp2d_pkg::*;

  logic [12:0] plane_height_q, plane_height_d;
  logic [8:0]  plane_width_q, plane_width_d;
  logic [3:0]  window_height_q, window_height_d;
  logic [3:0]  window_width_q, window_width_d;
  logic [3:0]  step_rows_q, step_rows_d;
  logic [3:0]  step_cols_q, step_cols_d;
  logic [15:0] plane_count_q, plane_count_d;
  logic        wr_en;
  logic        wr_hit;
  reg_idx_e    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[4:2]);

  // Register write decode.
  always_comb begin
    plane_height_d  = plane_height_q;
    plane_width_d   = plane_width_q;
    window_height_d = window_height_q;
    window_width_d  = window_width_q;
    step_rows_d     = step_rows_q;
    step_cols_d     = step_cols_q;
    plane_count_d   = plane_count_q;
    wr_hit          = 1'b0;
    if (wr_en) begin
      wr_hit = 1'b1;
      unique case (idx)
        REG_PLANE_HEIGHT:  plane_height_d  = pwdata[12:0];
        REG_PLANE_WIDTH:   plane_width_d   = pwdata[8:0];
        REG_WINDOW_HEIGHT: window_height_d = pwdata[3:0];
        REG_WINDOW_WIDTH:  window_width_d  = pwdata[3:0];
        REG_STEP_ROWS:     step_rows_d     = pwdata[3:0];
        REG_STEP_COLS:     step_cols_d     = pwdata[3:0];
        REG_PLANE_COUNT:   plane_count_d   = pwdata[15:0];
        default:           wr_hit          = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_height_q  <= 13'd1;
      plane_width_q   <= 9'd1;
      window_height_q <= 4'd1;
      window_width_q  <= 4'd1;
      step_rows_q     <= 4'd1;
      step_cols_q     <= 4'd1;
      plane_count_q   <= 16'd1;
    end else begin
      plane_height_q  <= plane_height_d;
      plane_width_q   <= plane_width_d;
      window_height_q <= window_height_d;
      window_width_q  <= window_width_d;
      step_rows_q     <= step_rows_d;
      step_cols_q     <= step_cols_d;
      plane_count_q   <= plane_count_d;
    end
  end

  // Read-back of the raw register values.
  always_comb begin
    unique case (idx)
      REG_PLANE_HEIGHT:  prdata = DATA_W'(plane_height_q);
      REG_PLANE_WIDTH:   prdata = DATA_W'(plane_width_q);
      REG_WINDOW_HEIGHT: prdata = DATA_W'(window_height_q);
      REG_WINDOW_WIDTH:  prdata = DATA_W'(window_width_q);
      REG_STEP_ROWS:     prdata = DATA_W'(step_rows_q);
      REG_STEP_COLS:     prdata = DATA_W'(step_cols_q);
      REG_PLANE_COUNT:   prdata = DATA_W'(plane_count_q);
      default:           prdata = '0;
    endcase
  end

  // Effective geometry: zero counts as one, widths and windows are capped.
  always_comb begin
    cfg_o.h  = (plane_height_q == 13'd0) ? ROW_W'(1) : plane_height_q;
    if (plane_width_q == 9'd0) begin
      cfg_o.w = WEFF_W'(1);
    end else if (int'(plane_width_q) > MAX_WIDTH) begin
      cfg_o.w = WEFF_W'(MAX_WIDTH);
    end else begin
      cfg_o.w = WEFF_W'(plane_width_q);
    end
    cfg_o.wh = clamp_win(window_height_q);
    cfg_o.ww = clamp_win(window_width_q);
    cfg_o.sr = (step_rows_q == 4'd0) ? STEP_W'(1) : step_rows_q;
    cfg_o.sc = (step_cols_q == 4'd0) ? STEP_W'(1) : step_cols_q;
    cfg_o.pc = (plane_count_q == 16'd0) ? PCOUNT_W'(1) : plane_count_q;
  end

  // Any register write restarts the stream with the window size just written.
  assign restart_o.restart = wr_hit;
  assign restart_o.wh      = clamp_win(window_height_d);
  assign restart_o.ww      = clamp_win(window_width_d);

endmodule

`default_nettype wire

// ----- sv/mp2d_ctrl.sv -----
`default_nettype none

module mp2d_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mp2d_pkg::cfg_t     cfg_i,
  input  wire mp2d_pkg::restart_t restart_i,
  input  wire logic               accept_i,
  output mp2d_pkg::col_t          col_o,
  output mp2d_pkg::item_t         item_o
);
  import mp2d_pkg::*;

  logic [ROW_W-1:0]    row_q, row_d;
  col_t                col_q, col_d;
  logic [PCOUNT_W-1:0] plane_q, plane_d;
  logic [NBR_W-1:0]    nbr_q, nbr_d;
  logic [NRC_W-1:0]    nrc_q, nrc_d;

  logic                hit_col;
  logic                hit_row;
  logic [WEFF_W-1:0]   col_inc;
  logic                last_col;
  logic [ROW_W-1:0]    row_inc;
  logic                last_row;
  logic [NBR_W:0]      bot_sum;
  logic [NRC_W:0]      rgt_sum;
  logic                last_res;
  logic [PCOUNT_W:0]   plane_inc;

  // Position compares for the sample at the head of the stream.
  always_comb begin
    hit_col   = NRC_W'(col_q) == nrc_q;
    hit_row   = NBR_W'(row_q) == nbr_q;
    col_inc   = WEFF_W'(col_q) + WEFF_W'(1);
    last_col  = col_inc >= cfg_i.w;
    row_inc   = row_q + ROW_W'(1);
    last_row  = row_inc >= cfg_i.h;
    bot_sum   = (NBR_W+1)'(nbr_q) + (NBR_W+1)'(cfg_i.sr);
    rgt_sum   = (NRC_W+1)'(nrc_q) + (NRC_W+1)'(cfg_i.sc);
    last_res  = (bot_sum >= (NBR_W+1)'(cfg_i.h)) && (rgt_sum >= (NRC_W+1)'(cfg_i.w));
    plane_inc = (PCOUNT_W+1)'(plane_q) + (PCOUNT_W+1)'(1);
  end

  // Result tags for the sample taken in this cycle.
  always_comb begin
    item_o.emit       = hit_row && hit_col;
    item_o.plane_done = hit_row && hit_col && last_res;
    item_o.all_done   = hit_row && hit_col && last_res &&
                        (plane_q == cfg_i.pc - PCOUNT_W'(1));
  end

  assign col_o = col_q;

  // Raster position and next window corner.
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    plane_d = plane_q;
    nbr_d   = nbr_q;
    nrc_d   = nrc_q;
    if (restart_i.restart) begin
      row_d   = '0;
      col_d   = '0;
      plane_d = '0;
      nbr_d   = NBR_W'(restart_i.wh) - NBR_W'(1);
      nrc_d   = NRC_W'(restart_i.ww) - NRC_W'(1);
    end else if (accept_i) begin
      if (hit_col) begin
        nrc_d = nrc_q + NRC_W'(cfg_i.sc);
      end
      if (last_col) begin
        col_d = '0;
        nrc_d = NRC_W'(cfg_i.ww) - NRC_W'(1);
        if (hit_row) begin
          nbr_d = nbr_q + NBR_W'(cfg_i.sr);
        end
        if (last_row) begin
          row_d   = '0;
          nbr_d   = NBR_W'(cfg_i.wh) - NBR_W'(1);
          plane_d = (plane_inc >= (PCOUNT_W+1)'(cfg_i.pc)) ? '0 : plane_inc[PCOUNT_W-1:0];
        end else begin
          row_d = row_inc;
        end
      end else begin
        col_d = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      plane_q <= '0;
      nbr_q   <= '0;
      nrc_q   <= '0;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      plane_q <= plane_d;
      nbr_q   <= nbr_d;
      nrc_q   <= nrc_d;
    end
  end

  // The position never leaves the plane.
  a_col_in_plane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WEFF_W'(col_q) < cfg_i.w)
    else $error("column index outside the plane");

  a_row_in_plane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q < cfg_i.h)
    else $error("row index outside the plane");

  // The end-of-stream mark only rides on an end-of-plane result.
  a_done_nesting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_o.all_done |-> (item_o.plane_done && item_o.emit))
    else $error("all_done without plane_done");

endmodule

`default_nettype wire

// ----- sv/mp2d_colmem.sv -----
`default_nettype none

module mp2d_colmem (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 accept_i,
  input  wire mp2d_pkg::sample_t    sample_i,
  input  wire mp2d_pkg::col_t       col_i,
  input  wire mp2d_pkg::item_t      item_i,
  input  wire mp2d_pkg::win_cnt_t   wh_i,
  output logic                      valid_o,
  output mp2d_pkg::sample_t         colmax_o,
  output mp2d_pkg::item_t           item_o
);
  import mp2d_pkg::*;

  // One word per column: the newest MAX_WINDOW samples of that column.
  col_word_t mem [MAX_WIDTH];

  col_word_t rdata_q;
  logic      s1_valid_q;
  sample_t   s1_sample_q;
  col_t      s1_col_q;
  item_t     s1_item_q;
  logic      fwd_q;
  col_word_t fwd_word_q;
  col_word_t base;
  col_word_t word_new;
  logic      s2_valid_q;
  col_word_t s2_word_q;
  item_t     s2_item_q;
  logic      s3_valid_q;
  sample_t   s3_colmax_q;
  item_t     s3_item_q;

  // Column memory: read on a transfer, written back from the s1 stage when the pipeline moves.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rdata_q <= mem[col_i];
    end
    if (en_i && s1_valid_q) begin
      mem[s1_col_q] <= word_new;
    end
  end

  // A back-to-back read of the column being written takes the new word.
  assign base     = fwd_q ? fwd_word_q : rdata_q;
  assign word_new = {base[MAX_WINDOW-2:0], s1_sample_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= accept_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sample_q <= sample_i;
      s1_col_q    <= col_i;
      s1_item_q   <= item_i;
      fwd_q       <= s1_valid_q && (s1_col_q == col_i);
      fwd_word_q  <= word_new;
      s2_word_q   <= word_new;
      s2_item_q   <= s1_item_q;
      s3_colmax_q <= win_max(s2_word_q, wh_i);
      s3_item_q   <= s2_item_q;
    end
  end

  assign valid_o  = s3_valid_q;
  assign colmax_o = s3_colmax_q;
  assign item_o   = s3_item_q;

  // A stalled pipeline keeps every stage in place.
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> ($stable(s1_valid_q) && $stable(s2_valid_q) && $stable(s3_valid_q)))
    else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

// ----- sv/mp2d_rowmax.sv -----
`default_nettype none

module mp2d_rowmax (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire mp2d_pkg::sample_t    colmax_i,
  input  wire mp2d_pkg::item_t      item_i,
  input  wire mp2d_pkg::win_cnt_t   ww_i,
  output logic                      out_valid_o,
  output mp2d_pkg::sample_t         pooled_value_o,
  output logic                      plane_done_o,
  output logic                      all_done_o
);
  import mp2d_pkg::*;

  // Column maxima of the current row, newest at entry 0.
  col_word_t cms_q;
  col_word_t row_word;
  sample_t   row_max;
  logic      out_valid_q;
  sample_t   pooled_q;
  logic      plane_done_q;
  logic      all_done_q;

  assign row_word = {cms_q[MAX_WINDOW-2:0], colmax_i};
  assign row_max  = win_max(row_word, ww_i);

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      cms_q <= row_word;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= valid_i && item_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i && item_i.emit) begin
      pooled_q     <= row_max;
      plane_done_q <= item_i.plane_done;
      all_done_q   <= item_i.all_done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pooled_value_o = pooled_q;
  assign plane_done_o   = plane_done_q;
  assign all_done_o     = all_done_q;

endmodule

`default_nettype wire

// ----- sv/max_pool_2d_stream.sv -----
`default_nettype none

// Streaming 2-D max pooling over signed Q16.16 samples in raster order, one
// plane after another. A result is a transfer on the output channel for each
// sample that closes a window lying wholly inside the plane; it carries the
// window maximum and marks the last result of a plane and of the last plane.
// The block takes one sample per cycle unless a held result stalls it, a
// rate set by the column memory: it holds the newest window rows of every
// column in one word, is read when a sample is taken and written back from
// the next stage (a plane one column wide forwards the word just written).
// The memory needs no clearing pass after reset. Registers must be written
// only while the stream is idle; the block does not enforce it. Any register
// write restarts the stream at the first sample of the first plane.
module max_pool_2d_stream (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mp2d_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mp2d_pkg::DATA_W-1:0] pwdata,
  output logic      [mp2d_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire mp2d_pkg::sample_t           sample_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output mp2d_pkg::sample_t                pooled_value_o,
  output logic                             plane_done_o,
  output logic                             all_done_o
);
  import mp2d_pkg::*;

  cfg_t     cfg;
  restart_t restart;
  logic     en;
  logic     accept;
  col_t     col;
  item_t    item;
  logic     s3_valid;
  sample_t  s3_colmax;
  item_t    s3_item;

  // The pipeline moves unless a waiting result is held by the consumer.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;

  mp2d_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  mp2d_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .restart_i (restart),
    .accept_i  (accept),
    .col_o     (col),
    .item_o    (item)
  );

  mp2d_colmem u_colmem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .accept_i (accept),
    .sample_i (sample_i),
    .col_i    (col),
    .item_i   (item),
    .wh_i     (cfg.wh),
    .valid_o  (s3_valid),
    .colmax_o (s3_colmax),
    .item_o   (s3_item)
  );

  mp2d_rowmax u_rowmax (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (s3_valid),
    .colmax_i       (s3_colmax),
    .item_i         (s3_item),
    .ww_i           (cfg.ww),
    .out_valid_o    (out_valid_o),
    .pooled_value_o (pooled_value_o),
    .plane_done_o   (plane_done_o),
    .all_done_o     (all_done_o)
  );

endmodule

`default_nettype wire

// ----- bench/tb_max_pool_2d_stream.sv -----
`timescale 1ns / 1ps

module tb_max_pool_2d_stream;
  import mp2d_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_SAMPLES = 700;
  localparam int HOLD_CYCLES = 300;
  localparam int REG_BITS [7] = '{13, 9, 4, 4, 4, 4, 16};
  localparam sample_t MOST_POS = sample_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});

  // Two planes of 2x4 samples pooled by 2x2 windows at stride 2, built from the
  // extreme values so that each window maximum is known in advance.
  localparam sample_t DIRECTED_SAMPLES [16] = '{
    MOST_NEG, MOST_NEG, MOST_POS, sample_t'(0),
    MOST_NEG, MOST_NEG, sample_t'(-1), sample_t'(1),
    sample_t'(-1), sample_t'(-2), sample_t'(0), sample_t'(0),
    sample_t'(-3), sample_t'(-1), sample_t'(0), sample_t'(-1)
  };

  typedef struct {
    sample_t value;
    logic    plane_done;
    logic    all_done;
  } pooled_t;

  // Tracks the stream position and line store, predicts every window maximum
  // and matches it against the results that leave the block.
  class pool_scoreboard;
    int unsigned raw_regs [7];
    int unsigned row, col, plane, bottom_row, right_col;
    sample_t     lines [MAX_WINDOW][MAX_WIDTH];
    pooled_t     pending [$];
    int          errors;
    int          checked;

    function new();
      foreach (raw_regs[i]) raw_regs[i] = 1;
      errors = 0;
      checked = 0;
      restart();
    endfunction

    function int unsigned clamped(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void restart();
      row = 0;
      col = 0;
      plane = 0;
      bottom_row = clamped(raw_regs[REG_WINDOW_HEIGHT], MAX_WINDOW) - 1;
      right_col = clamped(raw_regs[REG_WINDOW_WIDTH], MAX_WINDOW) - 1;
    endfunction

    // Any register write sends the stream back to its first sample.
    function void write_reg(reg_idx_e idx, logic [DATA_W-1:0] data);
      raw_regs[int'(idx)] = data & ((32'd1 << REG_BITS[int'(idx)]) - 1);
      restart();
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void take_sample(sample_t s);
      int unsigned h, w, wh, ww, sr, sc, pc, cidx, ridx;
      sample_t best;
      pooled_t res;
      h = clamped(raw_regs[REG_PLANE_HEIGHT], 32'hFFFFFF);
      w = clamped(raw_regs[REG_PLANE_WIDTH], MAX_WIDTH);
      wh = clamped(raw_regs[REG_WINDOW_HEIGHT], MAX_WINDOW);
      ww = clamped(raw_regs[REG_WINDOW_WIDTH], MAX_WINDOW);
      sr = clamped(raw_regs[REG_STEP_ROWS], 32'hFFFF);
      sc = clamped(raw_regs[REG_STEP_COLS], 32'hFFFF);
      pc = clamped(raw_regs[REG_PLANE_COUNT], 32'hFFFFFF);
      lines[row % MAX_WINDOW][col % MAX_WIDTH] = s;

      // This sample closes a window: take the maximum over its rows and columns.
      if (row == bottom_row && col == right_col) begin
        best = MOST_NEG;
        for (int k = 0; k < ww; k++) begin
          cidx = (col + 1 - ww + k) % MAX_WIDTH;
          for (int i = 0; i < wh; i++) begin
            ridx = row + 1 - wh + i;
            if (lines[ridx % MAX_WINDOW][cidx] > best) best = lines[ridx % MAX_WINDOW][cidx];
          end
        end
        res.value = best;
        res.plane_done = (bottom_row + sr > h - 1) && (right_col + sc > w - 1);
        res.all_done = res.plane_done && (plane == pc - 1);
        pending.push_back(res);
      end

      // Advance the stream position and the next window corner.
      if (col == right_col) right_col += sc;
      if (col + 1 >= w) begin
        col = 0;
        right_col = ww - 1;
        if (row == bottom_row) bottom_row += sr;
        if (row + 1 >= h) begin
          row = 0;
          bottom_row = wh - 1;
          plane = (plane + 1 >= pc) ? 0 : plane + 1;
        end else begin
          row++;
        end
      end else begin
        col++;
      end
    endfunction

    function void check_pooled(sample_t value, logic plane_done, logic all_done);
      pooled_t want;
      if (pending.size() == 0) begin
        note_error($sformatf("result %h (%b %b) arrived with no window pending",
                             value, plane_done, all_done));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (value !== want.value || plane_done !== want.plane_done ||
          all_done !== want.all_done) begin
        note_error($sformatf("result %0d: expected %h plane_done %b all_done %b, got %h %b %b",
                             checked, want.value, want.plane_done, want.all_done,
                             value, plane_done, all_done));
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  sample_t           sample = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  sample_t           pooled_value;
  logic              plane_done;
  logic              all_done;

  pool_scoreboard board = new();
  int          samples_sent = 0;
  int          settings_used = 0;
  int          idle_cycles = 0;
  bit          fast_src = 1'b0;
  bit          fast_sink = 1'b0;
  bit          steady_src = 1'b0;
  bit          hold_req = 1'b0;

  max_pool_2d_stream dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_i       (sample),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pooled_value_o (pooled_value),
    .plane_done_o   (plane_done),
    .all_done_o     (all_done)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Observe every transfer on both channels and guard against a hung run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        board.take_sample(sample);
        samples_sent++;
      end
      if (out_valid && !out_stall) board.check_pooled(pooled_value, plane_done, all_done);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d windows still pending.",
                 IDLE_LIMIT, board.pending.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Result side: random stall before each transfer, once a long hold-off.
  initial begin : result_sink
    int unsigned cycles;
    forever begin
      cycles = fast_sink ? 0 : $urandom_range(0, 7);
      if ($urandom_range(0, 40) == 0) fast_sink = !fast_sink;
      if (hold_req) begin
        cycles = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (cycles != 0) begin
        out_stall <= 1'b1;
        repeat (cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  function automatic sample_t draw_sample();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
    if (pick == 1) return sample_t'(int'($urandom_range(0, 8)) - 4);
    return sample_t'($urandom);
  endfunction

  // Offer one sample after a random gap and wait for its transfer.
  task automatic send_sample(sample_t v);
    int unsigned gap;
    gap = (fast_src || steady_src) ? 0 : $urandom_range(0, 7);
    if ($urandom_range(0, 40) == 0) fast_src = !fast_src;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Send n random samples; optionally stop halfway until every result is in.
  task automatic stream_samples(int n, bit pause_mid);
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
      end
      send_sample(draw_sample());
    end
    in_valid <= 1'b0;
  endtask

  // Setup and access cycle; the register takes the data at the access edge.
  task automatic apb_write(reg_idx_e idx, int unsigned value);
    logic [DATA_W-1:0] data;
    data = value;
    if ($urandom_range(0, 3) == 0) data = data | ($urandom << REG_BITS[int'(idx)]);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(int'(idx) * 4);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.write_reg(idx, data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Let the block drain, including samples that close no window, then reprogram.
  task automatic configure(int unsigned h, int unsigned w, int unsigned wh, int unsigned ww,
                           int unsigned sr, int unsigned sc, int unsigned pc);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    apb_write(REG_PLANE_HEIGHT, h);
    apb_write(REG_PLANE_WIDTH, w);
    apb_write(REG_WINDOW_HEIGHT, wh);
    apb_write(REG_WINDOW_WIDTH, ww);
    apb_write(REG_STEP_ROWS, sr);
    apb_write(REG_STEP_COLS, sc);
    apb_write(REG_PLANE_COUNT, pc);
    settings_used++;
  endtask

  // Mostly small planes and windows that fit, with occasional odd registers.
  task automatic random_phase();
    int unsigned h, w, wh, ww, sr, sc, pc, n;
    h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
    w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
    if ($urandom_range(0, 19) == 0) w = $urandom_range(200, 511);
    wh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
    ww = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
    sr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
    sc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
    pc = $urandom_range(0, 3);
    configure(h, w, wh, ww, sr, sc, pc);
    n = (h == 0 ? 1 : h) * (w == 0 ? 1 : (w > MAX_WIDTH ? MAX_WIDTH : w)) *
        (pc == 0 ? 1 : pc) * $urandom_range(1, 2);
    if (n > 300) n = 300;
    if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
    stream_samples(n, 1'b0);
  endtask

  initial begin : stimulus
    int start_count;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extreme sample values through two small planes.
    configure(2, 4, 2, 2, 2, 2, 2);
    foreach (DIRECTED_SAMPLES[i]) send_sample(DIRECTED_SAMPLES[i]);
    in_valid <= 1'b0;

    // All registers zero: every sample is a 1x1 window. The sink holds off
    // for a long stretch so the block backs up into its input.
    configure(0, 0, 0, 0, 0, 0, 0);
    steady_src = 1'b1;
    hold_req = 1'b1;
    stream_samples(100, 1'b0);
    steady_src = 1'b0;

    // Largest height, step and plane count with the largest window height.
    configure(13'h1FFF, 1, 8, 1, 15, 15, 16'hFFFF);
    stream_samples(40, 1'b0);

    // Width above the line store and an oversized window width.
    configure(2, 9'h1FF, 2, 15, 1, 7, 1);
    stream_samples(300, 1'b0);

    // Window taller than the plane: no results, but planes keep counting.
    configure(3, 4, 4, 2, 1, 1, 2);
    stream_samples(30, 1'b0);

    // Oversized window height over a 9x9 plane, wrapping past the stream end,
    // with the sender waiting halfway for every result.
    configure(9, 9, 9, 12, 1, 1, 1);
    stream_samples(100, 1'b1);

    start_count = samples_sent;
    while (samples_sent - start_count < RANDOM_SAMPLES) random_phase();

    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Run covered %0d samples under %0d register settings.", samples_sent,
             settings_used);
    $display("%0d pooled results compared, %0d mismatches.", board.checked, board.errors);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
